[sv/cdda_pkg.sv]
// shared constants and types for the clipped dda line walker
`timescale 1ns / 1ps
package cdda_pkg;
    localparam int MaxDim = 4096;
    localparam int FracBits = 16;
    localparam int CoordW = 16;
    localparam int ClipW = 13;
    localparam int PixW = 12;
    localparam int PosW = 18;
    localparam int AccW = 48;
    localparam int SlopeW = 18;
    localparam int DeltaW = 17;

    localparam logic [1:0] RegLeft = 2'd0;
    localparam logic [1:0] RegTop = 2'd1;
    localparam logic [1:0] RegRight = 2'd2;
    localparam logic [1:0] RegBottom = 2'd3;

    localparam logic OpLoad = 1'b0;
    localparam logic OpStep = 1'b1;

    typedef struct packed {
        logic [ClipW-1:0] left;
        logic [ClipW-1:0] top;
        logic [ClipW-1:0] right;
        logic [ClipW-1:0] bottom;
    } t_clip;

    // classified item passed from front to back
    typedef struct packed {
        logic               is_step;
        logic signed [CoordW:0] x1;
        logic signed [CoordW:0] y1;
        logic [DeltaW-1:0]  dx;
        logic [DeltaW-1:0]  dy;
        logic               dy_neg;
        logic               dx_neg;
    } t_item;
endpackage

[sv/cdda_front.sv]
// front end: accepts items, orients the line, pushes into the queue
`timescale 1ns / 1ps
module cdda_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_op,
    input  logic signed [cdda_pkg::CoordW-1:0] i_x_start,
    input  logic signed [cdda_pkg::CoordW-1:0] i_y_start,
    input  logic signed [cdda_pkg::CoordW-1:0] i_x_end,
    input  logic signed [cdda_pkg::CoordW-1:0] i_y_end,
    output logic                              o_q_valid,
    input  logic                              i_q_pop,
    output cdda_pkg::t_item                   o_q_item
);
    localparam int W = cdda_pkg::CoordW + 2;
    cdda_pkg::t_item r_q0, r_q1, n_item;
    logic [1:0] r_cnt;
    logic signed [W-1:0] x1, y1, dx, dy, s;
    logic push;

    always_comb begin
        x1 = W'(i_x_start);
        y1 = W'(i_y_start);
        dx = W'(i_x_end) - x1;
        dy = W'(i_y_end) - y1;
        s = dx + dy;
        if (s < 0) begin
            x1 = x1 + dx;
            y1 = y1 + dy;
            dx = -dx;
            dy = -dy;
        end
        n_item.is_step = (i_op == cdda_pkg::OpStep);
        n_item.x1 = x1[cdda_pkg::CoordW:0];
        n_item.y1 = y1[cdda_pkg::CoordW:0];
        n_item.dx_neg = dx[W-1];
        n_item.dy_neg = dy[W-1];
        n_item.dx = dx[W-1] ? cdda_pkg::DeltaW'(-dx) : cdda_pkg::DeltaW'(dx);
        n_item.dy = dy[W-1] ? cdda_pkg::DeltaW'(-dy) : cdda_pkg::DeltaW'(dy);
    end

    assign o_stall = (r_cnt == 2'd2);
    assign push = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item = r_q0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
        if (i_q_pop) begin
            r_q0 <= (r_cnt == 2'd2) ? r_q1 : n_item;
            if (push && r_cnt == 2'd2) r_q1 <= n_item;
        end else if (push) begin
            if (r_cnt == 2'd0) r_q0 <= n_item;
            else r_q1 <= n_item;
        end
    end
endmodule

[sv/cdda_div.sv]
// restoring divider for the rounded slope quotient
`timescale 1ns / 1ps
module cdda_div #(
    parameter int NumW = 36,
    parameter int DenW = 18
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [NumW-1:0] i_num,
    input  logic [DenW-1:0] i_den,
    output logic            o_done,
    output logic [NumW-1:0] o_quot,
    output logic            o_rem_nz
);
    localparam int CntW = $clog2(NumW + 1);
    logic [NumW-1:0] r_q;
    logic [DenW:0]   r_r;
    logic [DenW-1:0] r_d;
    logic [CntW-1:0] r_cnt;
    logic            r_busy;
    logic [DenW:0]   sh, df;

    assign sh = {r_r[DenW-1:0], r_q[NumW-1]};
    assign df = sh - {1'b0, r_d};
    assign o_quot = r_q;
    assign o_rem_nz = (r_r != '0);
    assign o_done = r_busy && (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt <= CntW'(NumW);
            r_q <= i_num;
            r_r <= '0;
            r_d <= i_den;
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
                if (!df[DenW]) begin
                    r_r <= df;
                    r_q <= {r_q[NumW-2:0], 1'b1};
                end else begin
                    r_r <= sh;
                    r_q <= {r_q[NumW-2:0], 1'b0};
                end
            end
        end
    end
endmodule

[sv/cdda_back.sv]
// back end: slope setup, start clipping and the step walk
`timescale 1ns / 1ps
module cdda_back #(
    parameter int FracBits = cdda_pkg::FracBits
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  cdda_pkg::t_clip             i_clip,
    input  logic                        i_q_valid,
    output logic                        o_q_pop,
    input  cdda_pkg::t_item             i_q_item,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [cdda_pkg::PixW-1:0]   o_pixel_x,
    output logic [cdda_pkg::PixW-1:0]   o_pixel_y,
    output logic                        o_plotted,
    output logic                        o_stepped,
    output logic                        o_last
);
    localparam int DW = cdda_pkg::DeltaW;
    localparam int NumW = DW + FracBits + 2;
    localparam int AW = cdda_pkg::AccW;
    localparam int PW = cdda_pkg::PosW;
    localparam int SW = cdda_pkg::SlopeW;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_MUL  = 5'b00100,
        S_FIN  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;
    t_state r_state;

    logic signed [AW-1:0] r_acc;
    logic signed [SW-1:0] r_slope;
    logic signed [PW-1:0] r_pos, r_fin, r_skip;
    logic                 r_xmaj, r_active;
    logic                 r_oval;
    logic [cdda_pkg::PixW-1:0] r_px, r_py;
    logic r_plot, r_stp, r_last;
    logic r_neg;
    logic signed [PW-1:0] r_mpos;
    logic signed [AW-1:0] r_prod;
    cdda_pkg::t_item r_it;

    logic out_free, div_start, div_done, div_rnz, set_oval;
    logic [NumW-1:0] div_num, div_q, sh_mag;
    logic [DW:0] div_den;
    logic [DW-1:0] sh, lg;
    logic sh_neg, num_neg, xmaj_in;
    logic signed [PW-1:0] minor;
    logic in_win;
    logic signed [PW-1:0] lo, hi;
    logic signed [SW-1:0] slope_v;
    logic signed [PW+SW-1:0] skip_prod;

    assign out_free = !r_oval || !i_stall;
    assign o_valid = r_oval;
    assign o_pixel_x = r_px;
    assign o_pixel_y = r_py;
    assign o_plotted = r_plot;
    assign o_stepped = r_stp;
    assign o_last = r_last;

    assign o_q_pop = (r_state == S_IDLE) && i_q_valid && out_free;
    assign div_start = o_q_pop && !i_q_item.is_step;
    assign set_oval = (o_q_pop && i_q_item.is_step) || ((r_state == S_OUT) && out_free);
    assign skip_prod = r_skip * r_slope;

    // magnitudes: shorter over longer, sign of the rounded numerator kept separately
    always_comb begin
        xmaj_in = !i_q_item.dx_neg && (i_q_item.dy_neg || i_q_item.dx > i_q_item.dy);
        if (xmaj_in) begin
            sh = i_q_item.dy;
            lg = i_q_item.dx;
            sh_neg = i_q_item.dy_neg;
        end else begin
            sh = i_q_item.dx;
            lg = i_q_item.dy;
            sh_neg = i_q_item.dx_neg;
        end
        sh_mag = NumW'(sh) << (FracBits + 1);
        num_neg = 1'b0;
        if (!sh_neg) begin
            div_num = sh_mag + NumW'(lg);
        end else if (sh_mag >= NumW'(lg)) begin
            div_num = sh_mag - NumW'(lg);
            num_neg = 1'b1;
        end else begin
            div_num = NumW'(lg) - sh_mag;
        end
        div_den = {lg, 1'b0};
    end

    cdda_div #(.NumW(NumW), .DenW(DW + 1)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(div_num), .i_den(div_den),
        .o_done(div_done), .o_quot(div_q), .o_rem_nz(div_rnz)
    );

    always_comb begin
        // sign-magnitude num: negative needs floor = -(q + rnz)
        slope_v = r_neg ? SW'(-$signed({1'b0, div_q}) - (div_rnz ? 1 : 0))
                        : SW'(div_q);
        if (r_it.dx == '0 && r_it.dy == '0) slope_v = '0;
        minor = PW'(r_acc >>> FracBits);
        if (r_xmaj) in_win = minor >= $signed({1'b0, i_clip.top}) &&
                             minor < $signed({1'b0, i_clip.bottom});
        else in_win = minor >= $signed({1'b0, i_clip.left}) &&
                      minor < $signed({1'b0, i_clip.right});
        lo = r_xmaj ? PW'({1'b0, i_clip.left}) : PW'({1'b0, i_clip.top});
        hi = r_xmaj ? PW'({1'b0, i_clip.right}) : PW'({1'b0, i_clip.bottom});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_oval <= 1'b0;
            r_active <= 1'b0;
            r_xmaj <= 1'b0;
            r_acc <= '0;
            r_slope <= '0;
            r_pos <= '0;
            r_fin <= '0;
        end else begin
            if (r_oval && !i_stall && !set_oval) r_oval <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (o_q_pop) begin
                        if (i_q_item.is_step) begin
                            r_oval <= 1'b1;
                            r_px <= '0; r_py <= '0; r_plot <= 1'b0;
                            r_stp <= 1'b0; r_last <= 1'b0;
                            if (r_active) begin
                                r_stp <= 1'b1;
                                r_last <= (r_pos == r_fin);
                                if (in_win) begin
                                    r_plot <= 1'b1;
                                    r_px <= r_xmaj ? r_pos[cdda_pkg::PixW-1:0]
                                                   : minor[cdda_pkg::PixW-1:0];
                                    r_py <= r_xmaj ? minor[cdda_pkg::PixW-1:0]
                                                   : r_pos[cdda_pkg::PixW-1:0];
                                end
                                r_pos <= r_pos + 1'b1;
                                r_acc <= r_acc + AW'(r_slope);
                                if (r_pos == r_fin) r_active <= 1'b0;
                            end
                        end else begin
                            r_it <= i_q_item;
                            r_xmaj <= xmaj_in;
                            r_neg <= num_neg;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_slope <= slope_v;
                        if (r_xmaj) begin
                            r_acc <= (AW'(r_it.y1) <<< FracBits) + AW'(1 << (FracBits - 1));
                            r_mpos <= PW'(r_it.x1);
                            r_fin <= PW'(r_it.x1) + PW'(r_it.dx);
                        end else begin
                            r_acc <= (AW'(r_it.x1) <<< FracBits) + AW'(1 << (FracBits - 1));
                            r_mpos <= PW'(r_it.y1);
                            r_fin <= PW'(r_it.y1) + PW'(r_it.dy);
                        end
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_skip <= (r_mpos < lo) ? lo - r_mpos : '0;
                    r_pos <= (r_mpos < lo) ? lo : r_mpos;
                    if (r_fin >= hi) r_fin <= hi - 1'b1;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_prod <= AW'(skip_prod);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_acc <= r_acc + r_prod;
                        r_active <= (r_pos <= r_fin);
                        r_oval <= 1'b1;
                        r_px <= '0; r_py <= '0; r_plot <= 1'b0; r_stp <= 1'b0;
                        r_last <= !(r_pos <= r_fin);
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

[sv/clipped_dda_line_walker_top.sv]
// top level of the clipped dda line walker
// channel | signals                          | direction
// input   | i_valid/o_stall, op, endpoints   | in
// output  | o_valid/i_stall, pixel, flags    | out
// config  | apb psel/penable/pwrite/paddr    | in
// a step transaction is written from the queue head straight into the output register
// a load transaction passes S_DIV, S_MUL, S_FIN and S_OUT, using the 35-step slope divider
// reset clears clip window to full frame and ends any walk
// a two-entry queue lets input continue while the back end stalls on output
`timescale 1ns / 1ps
module clipped_dda_line_walker_top #(
    parameter int FracBits = cdda_pkg::FracBits
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [3:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_op,
    input  logic signed [cdda_pkg::CoordW-1:0] i_x_start,
    input  logic signed [cdda_pkg::CoordW-1:0] i_y_start,
    input  logic signed [cdda_pkg::CoordW-1:0] i_x_end,
    input  logic signed [cdda_pkg::CoordW-1:0] i_y_end,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [cdda_pkg::PixW-1:0]          o_pixel_x,
    output logic [cdda_pkg::PixW-1:0]          o_pixel_y,
    output logic                               o_plotted,
    output logic                               o_stepped,
    output logic                               o_last
);
    cdda_pkg::t_clip r_clip;
    cdda_pkg::t_item q_item;
    logic q_valid, q_pop;

    assign pready = 1'b1;
    always_comb begin
        unique case (paddr[3:2])
            cdda_pkg::RegLeft:   prdata = 32'(r_clip.left);
            cdda_pkg::RegTop:    prdata = 32'(r_clip.top);
            cdda_pkg::RegRight:  prdata = 32'(r_clip.right);
            default:             prdata = 32'(r_clip.bottom);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip.left <= '0;
            r_clip.top <= '0;
            r_clip.right <= cdda_pkg::ClipW'(cdda_pkg::MaxDim);
            r_clip.bottom <= cdda_pkg::ClipW'(cdda_pkg::MaxDim);
        end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
            unique case (paddr[3:2])
                cdda_pkg::RegLeft:   r_clip.left <= pwdata[cdda_pkg::ClipW-1:0];
                cdda_pkg::RegTop:    r_clip.top <= pwdata[cdda_pkg::ClipW-1:0];
                cdda_pkg::RegRight:  r_clip.right <= pwdata[cdda_pkg::ClipW-1:0];
                default:             r_clip.bottom <= pwdata[cdda_pkg::ClipW-1:0];
            endcase
        end
    end

    cdda_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_op(i_op), .i_x_start(i_x_start), .i_y_start(i_y_start),
        .i_x_end(i_x_end), .i_y_end(i_y_end),
        .o_q_valid(q_valid), .i_q_pop(q_pop), .o_q_item(q_item)
    );

    cdda_back #(.FracBits(FracBits)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_clip(r_clip),
        .i_q_valid(q_valid), .o_q_pop(q_pop), .i_q_item(q_item),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_pixel_x(o_pixel_x), .o_pixel_y(o_pixel_y), .o_plotted(o_plotted),
        .o_stepped(o_stepped), .o_last(o_last)
    );
endmodule

[tb/clipped_dda_line_walker_top_test.sv]
// self-checking testbench for the clipped dda line walker top level
`timescale 1ns / 1ps
module clipped_dda_line_walker_top_test;

    typedef struct {
        logic [cdda_pkg::PixW-1:0] px;
        logic [cdda_pkg::PixW-1:0] py;
        logic plotted;
        logic stepped;
        logic last;
    } t_pixel;

    class pixel_scoreboard;
        longint clip_lo_x, clip_lo_y, clip_hi_x, clip_hi_y;
        longint acc, slope, pos, fin;
        bit x_major, walking;
        t_pixel pixels_due[$];
        int errors, loads, steps, plots;

        function new();
            clip_lo_x = 0;
            clip_lo_y = 0;
            clip_hi_x = cdda_pkg::MaxDim;
            clip_hi_y = cdda_pkg::MaxDim;
            acc = 0;
            slope = 0;
            pos = 0;
            fin = 0;
            x_major = 0;
            walking = 0;
            errors = 0;
            loads = 0;
            steps = 0;
            plots = 0;
        endfunction

        function void set_clip(logic [1:0] idx, logic [cdda_pkg::ClipW-1:0] val);
            case (idx)
                cdda_pkg::RegLeft: clip_lo_x = val;
                cdda_pkg::RegTop: clip_lo_y = val;
                cdda_pkg::RegRight: clip_hi_x = val;
                default: clip_hi_y = val;
            endcase
        endfunction

        function longint rounded_slope(longint shorter, longint longer);
            longint num, den, q;
            if (longer <= 0) return 0;
            num = 2 * shorter * (longint'(1) << cdda_pkg::FracBits) + longer;
            den = 2 * longer;
            q = num / den;
            if (num % den != 0 && num < 0) q--;
            return q;
        endfunction

        function int pending();
            return pixels_due.size();
        endfunction

        function void note_input(logic op, logic signed [cdda_pkg::CoordW-1:0] xs, ys, xe, ye);
            t_pixel r;
            longint x1, y1, dx, dy, lo, hi, minor;
            bit in_win;
            r = '{default: 0};
            if (op == cdda_pkg::OpLoad) begin
                loads++;
                x1 = xs;
                y1 = ys;
                dx = longint'(xe) - x1;
                dy = longint'(ye) - y1;
                if (dx + dy < 0) begin
                    x1 += dx;
                    dx = -dx;
                    y1 += dy;
                    dy = -dy;
                end
                x_major = dx > dy;
                if (x_major) begin
                    slope = rounded_slope(dy, dx);
                    acc = y1 * (longint'(1) << cdda_pkg::FracBits)
                          + (longint'(1) << (cdda_pkg::FracBits - 1));
                    pos = x1;
                    fin = x1 + dx;
                    lo = clip_lo_x;
                    hi = clip_hi_x;
                end else begin
                    slope = rounded_slope(dx, dy);
                    acc = x1 * (longint'(1) << cdda_pkg::FracBits)
                          + (longint'(1) << (cdda_pkg::FracBits - 1));
                    pos = y1;
                    fin = y1 + dy;
                    lo = clip_lo_y;
                    hi = clip_hi_y;
                end
                if (pos < lo) begin
                    acc += (lo - pos) * slope;
                    pos = lo;
                end
                if (fin >= hi) fin = hi - 1;
                walking = pos <= fin;
                r.last = !walking;
            end else if (walking) begin
                steps++;
                minor = acc >>> cdda_pkg::FracBits;
                if (x_major) in_win = minor >= clip_lo_y && minor < clip_hi_y;
                else in_win = minor >= clip_lo_x && minor < clip_hi_x;
                if (in_win) begin
                    plots++;
                    r.plotted = 1;
                    r.px = x_major ? pos[cdda_pkg::PixW-1:0] : minor[cdda_pkg::PixW-1:0];
                    r.py = x_major ? minor[cdda_pkg::PixW-1:0] : pos[cdda_pkg::PixW-1:0];
                end
                r.stepped = 1;
                r.last = pos == fin;
                pos++;
                acc += slope;
                if (pos > fin) walking = 0;
            end
            pixels_due.push_back(r);
        endfunction

        function void check_result(t_pixel got);
            t_pixel want;
            if (pixels_due.size() == 0) begin
                $error("unexpected transaction on output");
                errors++;
                return;
            end
            want = pixels_due.pop_front();
            if (got.px !== want.px) begin
                $error("pixel_x expected %0d actual %0d", want.px, got.px);
                errors++;
            end
            if (got.py !== want.py) begin
                $error("pixel_y expected %0d actual %0d", want.py, got.py);
                errors++;
            end
            if (got.plotted !== want.plotted) begin
                $error("plotted expected %0d actual %0d", want.plotted, got.plotted);
                errors++;
            end
            if (got.stepped !== want.stepped) begin
                $error("stepped expected %0d actual %0d", want.stepped, got.stepped);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last expected %0d actual %0d", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic i_clk, i_rst_n;
    logic psel, penable, pwrite, pready;
    logic [3:0] paddr;
    logic [31:0] pwdata, prdata;
    logic i_valid, o_stall, i_op;
    logic signed [cdda_pkg::CoordW-1:0] i_x_start, i_y_start, i_x_end, i_y_end;
    logic o_valid, i_stall;
    logic [cdda_pkg::PixW-1:0] o_pixel_x, o_pixel_y;
    logic o_plotted, o_stepped, o_last;

    pixel_scoreboard sb;
    int tx_idle_pct, rx_idle_pct, items_sent, cycles;
    bit stim_done;

    localparam int CycleLimit = 1000000;
    localparam int ItemTarget = 1400;

    clipped_dda_line_walker_top dut (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // output side: check and random stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result('{o_pixel_x, o_pixel_y, o_plotted, o_stepped, o_last});
        i_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end

    function automatic logic signed [cdda_pkg::CoordW-1:0] rnd_coord();
        return cdda_pkg::CoordW'($urandom);
    endfunction

    task automatic send(input logic op,
                        input logic signed [cdda_pkg::CoordW-1:0] xs, ys, xe, ye);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1;
        i_op <= op;
        i_x_start <= xs;
        i_y_start <= ys;
        i_x_end <= xe;
        i_y_end <= ye;
        do @(posedge i_clk); while (o_stall);
        sb.note_input(op, xs, ys, xe, ye);
        items_sent++;
    endtask

    task automatic walk_line(input logic signed [cdda_pkg::CoordW-1:0] xs, ys, xe, ye,
                             input int n);
        send(cdda_pkg::OpLoad, xs, ys, xe, ye);
        repeat (n) send(cdda_pkg::OpStep, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
    endtask

    task automatic wait_idle();
        i_valid <= 0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [cdda_pkg::ClipW-1:0] val);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {idx, 2'b00};
        pwdata <= 32'(val);
        @(posedge i_clk);
        penable <= 1;
        do @(posedge i_clk); while (!pready);
        psel <= 0;
        penable <= 0;
        sb.set_clip(idx, val);
    endtask

    task automatic set_window(input logic [cdda_pkg::ClipW-1:0] l, t, r, b);
        wait_idle();
        apb_write(cdda_pkg::RegLeft, l);
        apb_write(cdda_pkg::RegTop, t);
        apb_write(cdda_pkg::RegRight, r);
        apb_write(cdda_pkg::RegBottom, b);
    endtask

    task automatic random_window(input int kind);
        int l, t;
        l = $urandom_range(0, 120);
        t = $urandom_range(0, 120);
        case (kind % 4)
            0: set_window(cdda_pkg::ClipW'(l), cdda_pkg::ClipW'(t),
                          cdda_pkg::ClipW'(l + $urandom_range(1, 300)),
                          cdda_pkg::ClipW'(t + $urandom_range(1, 300)));
            1: set_window(0, 0, cdda_pkg::ClipW'(cdda_pkg::MaxDim),
                          cdda_pkg::ClipW'(cdda_pkg::MaxDim));
            2: set_window(cdda_pkg::ClipW'(l + 50), cdda_pkg::ClipW'(t),
                          cdda_pkg::ClipW'(l),
                          cdda_pkg::ClipW'(t + $urandom_range(0, 200)));
            default: set_window(cdda_pkg::ClipW'(cdda_pkg::MaxDim),
                                cdda_pkg::ClipW'(cdda_pkg::MaxDim), 0, 0);
        endcase
    endtask

    task automatic random_items(input int count);
        int stop, kind, x1, y1, x2, y2, n;
        stop = items_sent + count;
        kind = 0;
        while (items_sent < stop) begin
            if ((items_sent % 200) < 2 && items_sent > 40) begin
                random_window(kind);
                kind++;
            end
            n = $urandom_range(0, 99);
            if (n < 85) begin
                x1 = int'($urandom_range(0, 460)) - 60;
                y1 = int'($urandom_range(0, 460)) - 60;
                x2 = x1 + int'($urandom_range(0, 80)) - 40;
                y2 = y1 + int'($urandom_range(0, 80)) - 40;
                n = (x2 > x1 ? x2 - x1 : x1 - x2) + (y2 > y1 ? y2 - y1 : y1 - y2);
                walk_line(cdda_pkg::CoordW'(x1), cdda_pkg::CoordW'(y1),
                          cdda_pkg::CoordW'(x2), cdda_pkg::CoordW'(y2),
                          $urandom_range(0, (n > 60 ? 60 : n) + 2));
            end else if (n < 95) begin
                walk_line(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                          $urandom_range(0, 8));
            end else begin
                send(cdda_pkg::OpStep, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
            end
        end
    endtask

    initial begin
        i_rst_n = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = 0;
        pwdata = 0;
        i_valid = 0;
        i_op = cdda_pkg::OpLoad;
        i_x_start = 0;
        i_y_start = 0;
        i_x_end = 0;
        i_y_end = 0;
        sb = new();
        items_sent = 0;
        tx_idle_pct = 23;
        rx_idle_pct = 88;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // step before any load, point, flat runs, reversed, steep, extremes
        send(cdda_pkg::OpStep, 16'sh7fff, -16'sd32768, 16'sh7fff, -16'sd32768);
        walk_line(5, 5, 5, 5, 2);
        walk_line(2, 7, 9, 7, 9);
        walk_line(4, 9, 4, 1, 10);
        walk_line(10, 3, 1, 6, 11);
        walk_line(1, 8, 5, 2, 8);
        walk_line(-20, -5, 10, 4, 12);
        walk_line(-16'sd32768, -16'sd32768, 16'sh7fff, 16'sh7fff, 3);
        walk_line(16'sh7fff, -16'sd32768, -16'sd32768, 16'sh7fff, 3);
        walk_line(5000, 5000, 6000, 5100, 1);
        set_window(3, 2, 8, 6);
        walk_line(0, 0, 12, 4, 10);
        walk_line(0, 0, 3, 12, 8);
        set_window(cdda_pkg::ClipW'(cdda_pkg::MaxDim), cdda_pkg::ClipW'(cdda_pkg::MaxDim),
                   0, 0);
        walk_line(1, 1, 6, 2, 2);
        walk_line(1, 1, 2, 6, 3);

        random_items(ItemTarget / 3);
        tx_idle_pct = 88;
        rx_idle_pct = 23;
        random_items(ItemTarget / 3);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_items(ItemTarget / 3);

        wait_idle();
        $display("covered %0d transactions: %0d loads, %0d walk steps, %0d plotted pixels",
                 items_sent, sb.loads, sb.steps, sb.plots);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
